@@ sv/i2a_pkg.sv @@
// Shared types, character codes and helper functions for the integer to ASCII formatter.
// No dependencies; imported by i2a_cell, i2a_chain and integer_to_ascii_formatter.

package i2a_pkg;

  localparam int VALUE_BITS_DEF = 64;
  localparam int MAX_WIDTH_DEF  = 63;

  // Format modes carried on func.
  localparam logic [1:0] FUNC_SDEC = 2'd0;
  localparam logic [1:0] FUNC_UDEC = 2'd1;
  localparam logic [1:0] FUNC_HEXL = 2'd2;
  localparam logic [1:0] FUNC_HEXU = 2'd3;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_LOWER = 8'h61;
  localparam logic [7:0] CH_UPPER = 8'h41;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_CLEAR,
    CELL_CONV,
    CELL_SHIFT
  } cell_op_e;

  typedef struct packed {
    cell_op_e op;
    logic     dec;
  } cell_ctrl_t;

  // Number of digit cells needed for a value of the given bit count, decimal or hex.
  function automatic int num_digits(input int bits);
    int dec_n;
    int hex_n;
    dec_n = (bits * 30103 + 99999) / 100000;
    hex_n = (bits + 3) / 4;
    return (dec_n > hex_n) ? dec_n : hex_n;
  endfunction

  function automatic logic [7:0] digit_to_ascii(input logic [3:0] digit, input logic upper);
    logic [7:0] base;
    base = upper ? CH_UPPER : CH_LOWER;
    if (digit < 4'd10) begin
      return CH_ZERO + {4'd0, digit};
    end else begin
      return base + {4'd0, digit} - 8'd10;
    end
  endfunction

endpackage

@@ sv/i2a_cell.sv @@
// One digit cell of the conversion chain: shift-and-add-3 for decimal, plain shift for hex.
// Depends on i2a_pkg.

module i2a_cell import i2a_pkg::*; (
  input  logic       clk_i,
  input  cell_ctrl_t ctrl_i,
  input  logic       bit_i,
  input  logic [3:0] digit_i,
  output logic [3:0] digit_o,
  output logic       carry_o
);

  logic [3:0] digit_q, digit_d;
  logic [3:0] adj;

  // The carry depends only on this cell's own digit, so the chain has no ripple path.
  assign adj     = (ctrl_i.dec && (digit_q >= 4'd5)) ? digit_q + 4'd3 : digit_q;
  assign carry_o = adj[3];
  assign digit_o = digit_q;

  always_comb begin
    case (ctrl_i.op)
      CELL_CLEAR: digit_d = 4'd0;
      CELL_CONV:  digit_d = {adj[2:0], bit_i};
      CELL_SHIFT: digit_d = digit_i;
      default:    digit_d = digit_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    digit_q <= digit_d;
  end

endmodule

@@ sv/i2a_chain.sv @@
// Row of digit cells fed by the magnitude shift register; the top cell holds the leading digit.
// Depends on i2a_pkg and i2a_cell.

module i2a_chain import i2a_pkg::*; #(
  parameter int VALUE_BITS = VALUE_BITS_DEF,
  parameter int NUM_DIGITS = num_digits(VALUE_BITS_DEF)
) (
  input  logic                  clk_i,
  input  cell_ctrl_t            ctrl_i,
  input  logic [VALUE_BITS-1:0] mag_i,
  output logic [3:0]            top_digit_o
);

  logic [VALUE_BITS-1:0] val_q;
  logic [3:0]            digit [NUM_DIGITS];
  logic                  carry [NUM_DIGITS];

  // The magnitude loads when the cells clear and feeds its top bit into cell 0.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.op == CELL_CLEAR) begin
      val_q <= mag_i;
    end else if (ctrl_i.op == CELL_CONV) begin
      val_q <= {val_q[VALUE_BITS-2:0], 1'b0};
    end
  end

  for (genvar i = 0; i < NUM_DIGITS; i++) begin : g_cell
    logic       bit_in;
    logic [3:0] digit_in;
    if (i == 0) begin : g_first
      assign bit_in   = val_q[VALUE_BITS-1];
      assign digit_in = 4'd0;
    end else begin : g_next
      assign bit_in   = carry[i-1];
      assign digit_in = digit[i-1];
    end
    i2a_cell u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl_i),
      .bit_i   (bit_in),
      .digit_i (digit_in),
      .digit_o (digit[i]),
      .carry_o (carry[i])
    );
  end

  assign top_digit_o = digit[NUM_DIGITS-1];

endmodule

@@ sv/integer_to_ascii_formatter.sv @@
// Integer to ASCII formatter, top level. One word in gives a run of character words out.
// The magnitude passes bit-serially through the digit chain, then characters leave one per
// cycle while the receiver does not stall. A new word is taken only after the last
// character of the previous word has been emitted.
// Reset (rst_ni low, asynchronous) returns the control to idle and empties the output.

module integer_to_ascii_formatter import i2a_pkg::*; #(
  parameter int VALUE_BITS = VALUE_BITS_DEF,
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [63:0] value_i,
  input  logic [1:0]  func_i,
  input  logic [5:0]  width_i,
  input  logic        zero_pad_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  char_out_o,
  output logic        last_o
);

  localparam int NUM_DIGITS = num_digits(VALUE_BITS);
  localparam int NDW        = $clog2(NUM_DIGITS + 1);
  localparam int CW         = $clog2(VALUE_BITS);

  // Control flow: convert the magnitude bit by bit, drop leading zero digits,
  // work out the padding, then emit spaces, sign, zeros and digits in order.
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CONV = 3'd1;
  localparam logic [2:0] S_NORM = 3'd2;
  localparam logic [2:0] S_PREP = 3'd3;
  localparam logic [2:0] S_LEAD = 3'd4;
  localparam logic [2:0] S_SIGN = 3'd5;
  localparam logic [2:0] S_ZERO = 3'd6;
  localparam logic [2:0] S_DIGS = 3'd7;

  logic [2:0]     state_q, state_d;
  logic [CW-1:0]  cnt_q, cnt_d;
  logic [NDW-1:0] nd_q, nd_d;
  logic [5:0]     pad_q, pad_d;
  logic [5:0]     w_q;
  logic           neg_q, zp_q, dec_q, upper_q;

  logic           out_valid_q;
  logic [7:0]     char_q;
  logic           last_q;

  logic                  accept;
  logic                  out_free;
  logic [VALUE_BITS-1:0] raw;
  logic [VALUE_BITS-1:0] mag;
  logic                  neg_in;
  logic [5:0]            w_sat;
  logic [7:0]            used;
  logic [5:0]            pad_n;
  logic [3:0]            top_digit;
  cell_ctrl_t            ctrl;
  logic                  emit;
  logic [7:0]            emit_char;
  logic                  emit_last;

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && (state_q == S_IDLE);
  assign out_free   = !out_valid_q || !out_stall_i;

  // Only the low VALUE_BITS bits count; a negative signed value becomes its magnitude.
  // The most negative value wraps onto itself, which is the right unsigned magnitude.
  assign raw    = value_i[VALUE_BITS-1:0];
  assign neg_in = (func_i == FUNC_SDEC) && raw[VALUE_BITS-1];
  assign mag    = neg_in ? VALUE_BITS'(~raw + 1'b1) : raw;
  assign w_sat  = (32'(width_i) > MAX_WIDTH) ? 6'(MAX_WIDTH) : width_i;

  // Padding is whatever the width leaves after the digits and the sign, never negative.
  assign used  = 8'(nd_q) + {7'd0, neg_q};
  assign pad_n = ({2'b00, w_q} > used) ? 6'({2'b00, w_q} - used) : 6'd0;

  i2a_chain #(
    .VALUE_BITS (VALUE_BITS),
    .NUM_DIGITS (NUM_DIGITS)
  ) u_chain (
    .clk_i       (clk_i),
    .ctrl_i      (ctrl),
    .mag_i       (mag),
    .top_digit_o (top_digit)
  );

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    nd_d      = nd_q;
    pad_d     = pad_q;
    ctrl.op   = CELL_HOLD;
    ctrl.dec  = dec_q;
    emit      = 1'b0;
    emit_char = CH_SPACE;
    emit_last = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          ctrl.op = CELL_CLEAR;
          cnt_d   = CW'(VALUE_BITS - 1);
          nd_d    = NDW'(NUM_DIGITS);
          state_d = S_CONV;
        end
      end
      S_CONV: begin
        ctrl.op = CELL_CONV;
        if (cnt_q == '0) begin
          state_d = S_NORM;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      S_NORM: begin
        // Shift leading zeros out of the top cell, keeping at least one digit.
        if ((top_digit == 4'd0) && (nd_q > NDW'(1))) begin
          ctrl.op = CELL_SHIFT;
          nd_d    = nd_q - 1'b1;
        end else begin
          state_d = S_PREP;
        end
      end
      S_PREP: begin
        pad_d = pad_n;
        if ((pad_n != 6'd0) && !zp_q) begin
          state_d = S_LEAD;
        end else if (neg_q) begin
          state_d = S_SIGN;
        end else if (pad_n != 6'd0) begin
          state_d = S_ZERO;
        end else begin
          state_d = S_DIGS;
        end
      end
      S_LEAD: begin
        if (out_free) begin
          emit      = 1'b1;
          emit_char = CH_SPACE;
          pad_d     = pad_q - 1'b1;
          if (pad_q == 6'd1) begin
            state_d = neg_q ? S_SIGN : S_DIGS;
          end
        end
      end
      S_SIGN: begin
        if (out_free) begin
          emit      = 1'b1;
          emit_char = CH_MINUS;
          // Space padding is already used up here, so a count left means zeros follow.
          state_d   = (pad_q != 6'd0) ? S_ZERO : S_DIGS;
        end
      end
      S_ZERO: begin
        if (out_free) begin
          emit      = 1'b1;
          emit_char = CH_ZERO;
          pad_d     = pad_q - 1'b1;
          if (pad_q == 6'd1) begin
            state_d = S_DIGS;
          end
        end
      end
      S_DIGS: begin
        if (out_free) begin
          emit      = 1'b1;
          emit_char = digit_to_ascii(top_digit, upper_q);
          ctrl.op   = CELL_SHIFT;
          nd_d      = nd_q - 1'b1;
          if (nd_q == NDW'(1)) begin
            emit_last = 1'b1;
            state_d   = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      nd_q        <= '0;
      pad_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      nd_q    <= nd_d;
      pad_q   <= pad_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Format settings of the word in flight.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      w_q     <= w_sat;
      neg_q   <= neg_in;
      zp_q    <= zero_pad_i;
      dec_q   <= (func_i == FUNC_SDEC) || (func_i == FUNC_UDEC);
      upper_q <= (func_i == FUNC_HEXU);
    end
  end

  // Output register; it holds its word while the receiver stalls.
  always_ff @(posedge clk_i) begin
    if (emit) begin
      char_q <= emit_char;
      last_q <= emit_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign char_out_o  = char_q;
  assign last_o      = last_q;

endmodule
